/* design/rrab_pkg.sv */
`timescale 1ns / 1ps

package rrab_pkg;

	localparam int PHASE_W   = 2;
	localparam int CHAN_W    = 3;
	localparam int MASK_BITS = 6;
	localparam int IN_W      = 10;
	localparam int AVG_W     = 10;

	localparam logic [PHASE_W-1:0] PHASE_INIT   = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_CONFIG = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_SETTLE = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_READ   = 2'd3;

	localparam logic [CHAN_W-1:0]    RESET_CHANNEL = 3'd5;
	localparam logic [MASK_BITS-1:0] MASK_RESET    = 6'd32;

	// what the sequencer hands to the datapath for the current tick
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [CHAN_W-1:0]  chan;
		logic               is_read;
		logic               enabled;
	} seq_tick_t;

endpackage

/* design/rrab_ram.sv */
`timescale 1ns / 1ps

module rrab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/rrab_seq.sv */
`timescale 1ns / 1ps

module rrab_seq #(
	parameter int NUM_CHANNELS = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic                            cfg_we,
	input  logic [rrab_pkg::MASK_BITS-1:0]  cfg_mask,
	output rrab_pkg::seq_tick_t             tick
);
	import rrab_pkg::*;

	logic [MASK_BITS-1:0] mask_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [CHAN_W-1:0]    chan_q;

	logic [7:0]        mask_ext;
	logic [CHAN_W:0]   chan_inc;
	logic              is_read;
	logic              enabled;

	assign mask_ext = {{(8 - MASK_BITS){1'b0}}, mask_q};
	assign chan_inc = {1'b0, chan_q} + (CHAN_W + 1)'(1);
	assign is_read  = (phase_q == PHASE_READ);
	// channels past the parameter or the mask width never sample
	assign enabled  = ({1'b0, chan_q} < (CHAN_W + 1)'(NUM_CHANNELS)) && mask_ext[chan_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			phase_q <= PHASE_INIT;
			chan_q  <= RESET_CHANNEL;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_mask;
			end
			if (advance) begin
				case (phase_q)
					PHASE_READ: phase_q <= PHASE_CONFIG;
					default:    phase_q <= phase_q + PHASE_W'(1);
				endcase
				if (is_read) begin
					chan_q <= (chan_inc >= (CHAN_W + 1)'(NUM_CHANNELS))
						? '0 : chan_inc[CHAN_W-1:0];
				end
			end
		end
	end

	assign tick.phase   = phase_q;
	assign tick.chan    = chan_q;
	assign tick.is_read = is_read;
	assign tick.enabled = enabled;

endmodule

/* design/round_robin_adc_block_averager.sv */
`timescale 1ns / 1ps

// channel   signals                                            direction
// cfg       cfg_valid, cfg_ready, cfg_data[5:0]                in
// in        in_valid, in_ready, sample[9:0]                    in
// out       out_valid, out_ready, phase, channel,              out
//           sample_taken, average_valid, average[9:0]
//
// one beat in per cycle unless the output stalls, result via stage 1 and stage 2;
// per-channel sum and count live in a small ram with registered read,
// read on the input beat and written back when the result is registered.
// reset clears the entry valid flops, so the ram needs no clearing pass.
// an output stall holds the middle stage; while that stage and the output
// register are full, in_ready drops in the same cycle as out_ready.
module round_robin_adc_block_averager #(
	parameter int NUM_CHANNELS        = 6,
	parameter int SAMPLES_PER_AVERAGE = 8,
	parameter int SAMPLE_BITS         = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrab_pkg::MASK_BITS-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rrab_pkg::IN_W-1:0]      sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rrab_pkg::PHASE_W-1:0]   phase,
	output logic [rrab_pkg::CHAN_W-1:0]    channel,
	output logic                           sample_taken,
	output logic                           average_valid,
	output logic [rrab_pkg::AVG_W-1:0]     average
);
	import rrab_pkg::*;

	localparam int CNT_W  = $clog2(SAMPLES_PER_AVERAGE + 1);
	localparam int LOG_D  = $clog2(SAMPLES_PER_AVERAGE);
	localparam int SUM_W  = SAMPLE_BITS + LOG_D;
	localparam int ENT_W  = CNT_W + SUM_W;
	localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	// exact floor division by reciprocal: m = ceil(2^(n+l) / d)
	localparam int SH     = SUM_W + LOG_D;
	localparam int RW     = SUM_W + 2;
	localparam int PW     = SH + SAMPLE_BITS;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;

	seq_tick_t tick;
	logic      in_acc;
	logic      s1_adv;

	// stage 1: tick info while the ram read is in flight
	logic                   vld_s1_q;
	logic [PHASE_W-1:0]     phase_s1;
	logic [CHAN_W-1:0]      chan_s1;
	logic                   act_s1;
	logic                   ent_vld_s1;
	logic [AW-1:0]          addr_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// stage 2: output register
	logic                   out_vld_q;
	logic [PHASE_W-1:0]     phase_s2;
	logic [CHAN_W-1:0]      chan_s2;
	logic                   taken_s2;
	logic                   avg_vld_s2;
	logic [SAMPLE_BITS-1:0] avg_s2;

	logic [NUM_CHANNELS-1:0] ent_vld_q;
	logic [AW-1:0]           rd_addr;
	logic                    rd_en;
	logic [ENT_W-1:0]        rd_data;
	logic [ENT_W-1:0]        wr_data;
	logic                    wr_en;

	logic [CNT_W-1:0] cur_cnt;
	logic [SUM_W-1:0] cur_sum;
	logic             full;
	logic [RW-1:0]    recip;
	logic [PW-1:0]    prod;

	assign cfg_ready = 1'b1;
	assign in_ready  = !vld_s1_q || s1_adv;
	assign in_acc    = in_valid && in_ready;
	assign s1_adv    = vld_s1_q && (!out_vld_q || out_ready);

	rrab_seq #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (in_acc),
		.cfg_we   (cfg_valid),
		.cfg_mask (cfg_data),
		.tick     (tick)
	);

	assign rd_addr = tick.chan[AW-1:0];
	assign rd_en   = in_acc && tick.is_read && tick.enabled;

	rrab_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// an entry never written since reset reads as zero
	assign cur_cnt = ent_vld_s1 ? rd_data[ENT_W-1 -: CNT_W] : '0;
	assign cur_sum = ent_vld_s1 ? rd_data[SUM_W-1:0] : '0;
	assign full    = (cur_cnt >= CNT_W'(SAMPLES_PER_AVERAGE));
	assign recip   = RW'(RECIP);
	assign prod    = PW'(cur_sum) * PW'(recip);

	assign wr_en   = s1_adv && act_s1;
	assign wr_data = full ? '0
		: {cur_cnt + CNT_W'(1), cur_sum + SUM_W'(sample_s1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q  <= 1'b0;
			out_vld_q <= 1'b0;
			ent_vld_q <= '0;
		end else begin
			if (in_acc) begin
				vld_s1_q <= 1'b1;
			end else if (s1_adv) begin
				vld_s1_q <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en) begin
				ent_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			phase_s1   <= tick.phase;
			chan_s1    <= tick.chan;
			act_s1     <= tick.is_read && tick.enabled;
			addr_s1    <= rd_addr;
			ent_vld_s1 <= tick.is_read && tick.enabled && ent_vld_q[rd_addr];
			sample_s1  <= SAMPLE_BITS'(sample);
		end
		if (s1_adv) begin
			phase_s2   <= phase_s1;
			chan_s2    <= chan_s1;
			taken_s2   <= act_s1 && !full;
			avg_vld_s2 <= act_s1 && full;
			avg_s2     <= (act_s1 && full) ? prod[SH +: SAMPLE_BITS] : '0;
		end
	end

	assign out_valid     = out_vld_q;
	assign phase         = phase_s2;
	assign channel       = chan_s2;
	assign sample_taken  = taken_s2;
	assign average_valid = avg_vld_s2;
	assign average       = AVG_W'(avg_s2);

endmodule
